// ===== src/tpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared sizes, codes and types of the three-level priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int DEPTH    = 4;
    localparam int LEVELS   = 3;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1;
    localparam int LVL_W    = 2;
    localparam int PADDR_W  = 3;
    localparam int REGIDX_W = PADDR_W - 2;

    localparam logic [DATA_W-1:0] LOW_THR_RESET  = 32'sd10;
    localparam logic [DATA_W-1:0] HIGH_THR_RESET = 32'sd100;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [REGIDX_W-1:0] REG_LOW_THR  = 1'b0;
    localparam logic [REGIDX_W-1:0] REG_HIGH_THR = 1'b1;

    typedef enum logic [LVL_W-1:0] {
        LVL_TOP = 2'd0,
        LVL_MID = 2'd1,
        LVL_BOT = 2'd2
    } t_level;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

// ===== src/three_level_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Three circular FIFOs sharing one synchronous store, served by fixed priority.
// ----------------------------------------------------------------------------
// Each item is an enqueue or a dequeue. An enqueued value is classed against
// the two signed thresholds and written to the top, middle or bottom FIFO;
// a full FIFO drops it and flags dropped. A dequeue serves the oldest entry
// of the highest non-empty level, or flags all_empty. Every item yields one
// result in the cycle after acceptance, and a new item is accepted every cycle
// as long as the result side keeps up: the read and write pointers and fill
// counts sit in flip-flops, the values in a single-port store of
// 3 x DEPTH words whose registered read data feeds the result.
// Thresholds are written through the APB port at byte addresses 0 and 4.
module three_level_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tpq_pkg::PADDR_W-1:0]         paddr,
    input  logic [tpq_pkg::DATA_W-1:0]          pwdata,
    output logic [tpq_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic signed [tpq_pkg::DATA_W-1:0]   i_value,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [tpq_pkg::DATA_W-1:0]   o_data_out,
    output logic                                o_served,
    output logic                                o_all_empty,
    output logic                                o_dropped,
    output logic [tpq_pkg::LVL_W-1:0]           o_level
);
    import tpq_pkg::*;

    logic signed [DATA_W-1:0] r_low_thr;
    logic signed [DATA_W-1:0] r_high_thr;

    t_idx r_rd_idx [LEVELS];
    t_idx r_wr_idx [LEVELS];
    t_cnt r_cnt    [LEVELS];

    logic [DATA_W-1:0] r_store [LEVELS * DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic   r_out_valid;
    logic   r_served;
    logic   r_all_empty;
    logic   r_dropped;
    t_level r_level;

    logic              accept;
    logic              cfg_wr;
    logic [REGIDX_W-1:0] reg_idx;
    t_level            enq_lvl;
    t_level            deq_lvl;
    logic              deq_found;
    logic              enq_full;
    logic              do_write;
    logic              do_read;
    t_level            op_lvl;
    logic [ADDR_W-1:0] mem_addr;
    t_idx              op_idx;

    function automatic t_idx next_idx(input t_idx i);
        next_idx = (i == t_idx'(DEPTH - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            REG_LOW_THR:  prdata = r_low_thr;
            REG_HIGH_THR: prdata = r_high_thr;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= LOW_THR_RESET;
            r_high_thr <= HIGH_THR_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LOW_THR:  r_low_thr  <= pwdata;
                REG_HIGH_THR: r_high_thr <= pwdata;
                default:      ;
            endcase
        end
    end

    // Classification and priority selection.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_value < r_low_thr) begin
            enq_lvl = LVL_TOP;
        end else if (i_value < r_high_thr) begin
            enq_lvl = LVL_MID;
        end else begin
            enq_lvl = LVL_BOT;
        end
    end

    always_comb begin
        deq_found = 1'b1;
        if (r_cnt[LVL_TOP] != '0) begin
            deq_lvl = LVL_TOP;
        end else if (r_cnt[LVL_MID] != '0) begin
            deq_lvl = LVL_MID;
        end else if (r_cnt[LVL_BOT] != '0) begin
            deq_lvl = LVL_BOT;
        end else begin
            deq_lvl   = LVL_TOP;
            deq_found = 1'b0;
        end
    end

    assign enq_full = (r_cnt[enq_lvl] == t_cnt'(DEPTH));
    assign do_write = accept && (i_mode == MODE_ENQ) && !enq_full;
    assign do_read  = accept && (i_mode == MODE_DEQ) && deq_found;
    assign op_lvl   = (i_mode == MODE_ENQ) ? enq_lvl : deq_lvl;
    assign op_idx   = (i_mode == MODE_ENQ) ? r_wr_idx[op_lvl] : r_rd_idx[op_lvl];
    assign mem_addr = ADDR_W'(ADDR_W'(op_lvl) * ADDR_W'(DEPTH)) + ADDR_W'(op_idx);

    // Value store: one port, read data registered.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[mem_addr] <= i_value;
        end
        if (do_read) begin
            r_rd_data <= r_store[mem_addr];
        end
    end

    // Pointers, fill counts and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVELS; k++) begin
                r_rd_idx[k] <= '0;
                r_wr_idx[k] <= '0;
                r_cnt[k]    <= '0;
            end
            r_out_valid <= 1'b0;
            r_served    <= 1'b0;
            r_all_empty <= 1'b0;
            r_dropped   <= 1'b0;
            r_level     <= LVL_TOP;
        end else begin
            if (do_write) begin
                r_wr_idx[op_lvl] <= next_idx(r_wr_idx[op_lvl]);
                r_cnt[op_lvl]    <= t_cnt'(r_cnt[op_lvl] + 1'b1);
            end
            if (do_read) begin
                r_rd_idx[op_lvl] <= next_idx(r_rd_idx[op_lvl]);
                r_cnt[op_lvl]    <= t_cnt'(r_cnt[op_lvl] - 1'b1);
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_level     <= op_lvl;
                r_served    <= (i_mode == MODE_DEQ) && deq_found;
                r_all_empty <= (i_mode == MODE_DEQ) && !deq_found;
                r_dropped   <= (i_mode == MODE_ENQ) && enq_full;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_out  = r_served ? r_rd_data : '0;
    assign o_served    = r_served;
    assign o_all_empty = r_all_empty;
    assign o_dropped   = r_dropped;
    assign o_level     = r_level;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the three-level priority queue.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver that sends them in random
// bursts. At each accepted item a predictor of the three circular FIFOs works
// out the result, and a clocked monitor compares every accepted result, field
// by field, with the oldest prediction. The thresholds are rewritten through
// the APB port between phases, while nothing is in flight, and read back.
// ----------------------------------------------------------------------------
module testbench;

    import tpq_pkg::*;

    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 178;
    localparam int MAX_PRINTED    = 50;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
    } queue_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic                     served;
        logic                     all_empty;
        logic                     dropped;
        t_level                   level;
    } queue_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_MOSTLY
    } ready_style_t;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [PADDR_W-1:0]       paddr   = '0;
    logic [DATA_W-1:0]        pwdata  = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_mode  = MODE_ENQ;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_data_out;
    logic                     o_served;
    logic                     o_all_empty;
    logic                     o_dropped;
    logic [LVL_W-1:0]         o_level;

    // Mirror of the block: thresholds, stored values, pointers and fill counts.
    logic signed [DATA_W-1:0] low_thr;
    logic signed [DATA_W-1:0] high_thr;
    logic signed [DATA_W-1:0] model_store [LEVELS][DEPTH];
    t_idx                     rd_ptr [LEVELS];
    t_idx                     wr_ptr [LEVELS];
    t_cnt                     occupancy [LEVELS];

    queue_op_t     pending_items [$];
    queue_result_t expected_results [$];
    int            error_count = 0;

    queue_op_t    next_op;
    int           burst_left = 0;
    int           gap_left = 0;
    int           presented_count = 0;
    logic         draining = 1'b0;
    int           stall_cycle = 0;
    ready_style_t stall_style = READY_ALWAYS;
    queue_result_t want;

    three_level_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_out  (o_data_out),
        .o_served    (o_served),
        .o_all_empty (o_all_empty),
        .o_dropped   (o_dropped),
        .o_level     (o_level)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_idx step_ptr(input t_idx p);
        return (p == t_idx'(DEPTH - 1)) ? '0 : t_idx'(p + 1'b1);
    endfunction

    function automatic void predict_queue_result(input logic mode,
                                                 input logic signed [DATA_W-1:0] value);
        queue_result_t res;
        t_level        lvl;
        res = '0;
        if (mode == MODE_ENQ) begin
            if (value < low_thr) begin
                lvl = LVL_TOP;
            end else if (value < high_thr) begin
                lvl = LVL_MID;
            end else begin
                lvl = LVL_BOT;
            end
            res.level = lvl;
            if (occupancy[lvl] >= DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                model_store[lvl][wr_ptr[lvl]] = value;
                wr_ptr[lvl] = step_ptr(wr_ptr[lvl]);
                occupancy[lvl] = occupancy[lvl] + 1'b1;
            end
        end else begin
            // The first non-empty level in priority order is served.
            res.all_empty = 1'b1;
            for (int k = 0; k < LEVELS; k++) begin
                if (res.all_empty && occupancy[k] != 0) begin
                    res.data_out  = model_store[k][rd_ptr[k]];
                    rd_ptr[k]     = step_ptr(rd_ptr[k]);
                    occupancy[k]  = occupancy[k] - 1'b1;
                    res.level     = t_level'(k);
                    res.served    = 1'b1;
                    res.all_empty = 1'b0;
                end
            end
        end
        expected_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        if (error_count < MAX_PRINTED) begin
            $display("%0t ns: %s mismatch: got 0x%08h, expected 0x%08h",
                     $time, what, got, exp_val);
        end
        error_count++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [REGIDX_W-1:0] reg_idx,
                                   input logic signed [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_idx == REG_LOW_THR) begin
            low_thr = value;
        end else begin
            high_thr = value;
        end
        // Read the register straight back on the same address.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== value) begin
            report_mismatch("register read-back", prdata, value);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: one item on the bus at a time, held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_mode     <= MODE_ENQ;
            i_value    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_queue_result(i_mode, i_value);
            end
            if (!(i_valid && !o_ready)) begin
                if (draining && expected_results.size() == 0) begin
                    draining = 1'b0;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (draining || pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    next_op = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_mode  <= next_op.mode;
                    i_value <= next_op.value;
                    presented_count++;
                    // Now and then the sender holds back until the queue has drained.
                    if (presented_count % 300 == 150) begin
                        draining = 1'b1;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted result and drives the stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready     <= 1'b0;
            stall_cycle = 0;
            stall_style = READY_ALWAYS;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_data_out, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_data_out !== want.data_out) begin
                        report_mismatch("data_out", o_data_out, want.data_out);
                    end
                    if (o_served !== want.served) begin
                        report_mismatch("served", 32'(o_served), 32'(want.served));
                    end
                    if (o_all_empty !== want.all_empty) begin
                        report_mismatch("all_empty", 32'(o_all_empty), 32'(want.all_empty));
                    end
                    if (o_dropped !== want.dropped) begin
                        report_mismatch("dropped", 32'(o_dropped), 32'(want.dropped));
                    end
                    if (o_level !== want.level) begin
                        report_mismatch("level", 32'(o_level), 32'(want.level));
                    end
                end
            end
            stall_cycle++;
            if (stall_cycle % 64 == 0) begin
                stall_style = ready_style_t'($urandom_range(0, 3));
            end
            case (stall_style)
                READY_ALWAYS: begin
                    i_ready <= 1'b1;
                end
                READY_COIN: begin
                    i_ready <= 1'($urandom_range(0, 1));
                end
                READY_SPARSE: begin
                    i_ready <= (stall_cycle % 4 == 0);
                end
                default: begin
                    i_ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    initial begin
        logic signed [DATA_W-1:0] directed_values [12];
        logic signed [DATA_W-1:0] thr_a;
        logic signed [DATA_W-1:0] thr_b;
        logic signed [DATA_W-1:0] v;
        queue_op_t                op;
        int                       enq_pct;

        low_thr  = LOW_THR_RESET;
        high_thr = HIGH_THR_RESET;
        for (int k = 0; k < LEVELS; k++) begin
            rd_ptr[k]    = '0;
            wr_ptr[k]    = '0;
            occupancy[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty dequeue, field extremes, a drop each on the full top
        // and bottom levels, then dequeues across all levels until empty again.
        directed_values = '{S32_MIN, 32'sd9, -32'sd1, 32'sd0, 32'sd5, 32'sd10, 32'sd99,
                            32'sd100, S32_MAX, 32'sd1000, 32'sd2000, 32'sd7777};
        pending_items.push_back('{MODE_DEQ, S32_MAX});
        foreach (directed_values[j]) begin
            pending_items.push_back('{MODE_ENQ, directed_values[j]});
        end
        for (int j = 0; j < 11; j++) begin
            pending_items.push_back('{MODE_DEQ, (j % 2 == 0) ? S32_MIN : 32'sd0});
        end
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    write_threshold(REG_LOW_THR, S32_MIN);
                    write_threshold(REG_HIGH_THR, S32_MAX);
                end
                2: begin
                    write_threshold(REG_LOW_THR, S32_MAX);
                    write_threshold(REG_HIGH_THR, S32_MIN);
                end
                3: begin
                    write_threshold(REG_LOW_THR, 32'sd0);
                    write_threshold(REG_HIGH_THR, 32'sd0);
                end
                4: begin
                    write_threshold(REG_LOW_THR, 32'sd50);
                    write_threshold(REG_HIGH_THR, -32'sd50);
                end
                5: begin
                    thr_a = $urandom;
                    thr_b = $urandom;
                    if (thr_b < thr_a) begin
                        v = thr_a;
                        thr_a = thr_b;
                        thr_b = v;
                    end
                    write_threshold(REG_LOW_THR, thr_a);
                    write_threshold(REG_HIGH_THR, thr_b);
                end
                6: begin
                    write_threshold(REG_LOW_THR, $urandom);
                    write_threshold(REG_HIGH_THR, $urandom);
                end
                7: begin
                    write_threshold(REG_LOW_THR, LOW_THR_RESET);
                    write_threshold(REG_HIGH_THR, HIGH_THR_RESET);
                end
                default: begin
                end
            endcase
            // Lean toward enqueues in some phases to hit full levels, toward
            // dequeues in others to drain them.
            enq_pct = 40 + 5 * ((phase * 3) % 7);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 7))
                    0, 1: v = $urandom;
                    2: v = low_thr + $signed($urandom_range(0, 4)) - 32'sd2;
                    3: v = high_thr + $signed($urandom_range(0, 4)) - 32'sd2;
                    4: v = S32_MIN;
                    5: v = S32_MAX;
                    default: v = $signed($urandom_range(0, 200)) - 32'sd50;
                endcase
                op.mode  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                op.value = (op.mode == MODE_ENQ) ? v : $signed($urandom);
                pending_items.push_back(op);
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tpq_pkg.sv
src/three_level_priority_queue.sv
verif/testbench.sv
